// ----- sv/adcsr_pkg.sv -----
`default_nettype none
package adcsr_pkg;

  localparam int unsigned SampleBits = 8;
  localparam int unsigned CountW     = 4;
  localparam int unsigned DivW       = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 16;

  localparam logic [CfgIdxW-1:0] CfgThreshold    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgChannel      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSingleEnded  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod   = 2'd3;

  localparam logic [SampleBits-1:0] ThresholdReset  = 8'd100;
  localparam logic [DivW-1:0]       HalfPeriodReset = 8'd1;

  localparam logic [CountW-1:0] LastCmdBit  = 4'd2;
  localparam logic [CountW-1:0] FirstMsbBit = 4'd1;
  localparam logic [CountW-1:0] LastMsbBit  = 4'(SampleBits);
  localparam logic [CountW-1:0] LastReadBit = 4'(2 * SampleBits - 1);

  typedef enum logic [5:0] {
    PhIdle  = 6'b000001,
    PhCmdLo = 6'b000010,
    PhCmdHi = 6'b000100,
    PhRdLo  = 6'b001000,
    PhRdHi  = 6'b010000,
    PhEndLo = 6'b100000
  } phase_e;

  typedef struct packed {
    logic                  alarm;
    logic                  match_ok;
    logic [SampleBits-1:0] sample;
    logic                  done_res;
    logic                  data_drive;
    logic                  data_out;
    logic                  serial_clock;
    logic                  chip_select_n;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/adc_serial_reader_with_alarm_top.sv -----
`default_nettype none
// Serial read master for a two-channel 8-bit converter. Each input item is one tick of
// the serial timing and yields exactly one result item carrying the line levels to drive
// after that tick, the done pulse, the held sample, the match flag and the alarm. The
// block takes one item per clock cycle: the whole tick update is a single registered pass
// from the accepted item into the result register, and a new item is accepted whenever
// that register is empty or being emptied in the same cycle.
module adc_serial_reader_with_alarm_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [adcsr_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [adcsr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // start_req, dio_in, zero fill
  input  wire logic [adcsr_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // chip_select_n, serial_clock, data_out, data_drive, done_res, sample[7:0],
  // match_ok, alarm, zero fill
  output logic [adcsr_pkg::OutDataW-1:0]      m_axis_tdata
);
  import adcsr_pkg::*;

  logic [SampleBits-1:0] threshold_q;
  logic                  channel_q;
  logic                  single_ended_q;
  logic [DivW-1:0]       half_period_q;

  phase_e                phase_q, phase_d;
  logic [CountW-1:0]     bit_count_q, bit_count_d;
  logic [DivW-1:0]       tick_div_q, tick_div_d;
  logic [SampleBits-1:0] msb_shift_q, msb_shift_d;
  logic [SampleBits-1:0] lsb_shift_q, lsb_shift_d;
  logic [SampleBits-1:0] sample_q, sample_d;
  logic                  match_q, match_d;

  logic                  out_valid_q;
  result_t               res_q, res_d;

  logic                  in_acc;
  logic                  start_req;
  logic                  dio_in;
  logic [DivW-1:0]       half_len;
  logic                  half_end;
  logic                  done;
  logic                  cmd_bit;

  assign start_req     = s_axis_tdata[0];
  assign dio_in        = s_axis_tdata[1];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= ThresholdReset;
      channel_q      <= 1'b0;
      single_ended_q <= 1'b1;
      half_period_q  <= HalfPeriodReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgThreshold:   threshold_q    <= cfg_wdata_i;
        CfgChannel:     channel_q      <= cfg_wdata_i[0];
        CfgSingleEnded: single_ended_q <= cfg_wdata_i[0];
        CfgHalfPeriod:  half_period_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign half_len = (half_period_q == '0) ? DivW'(1) : half_period_q;
  assign half_end = ({1'b0, tick_div_q} + 9'd1) >= {1'b0, half_len};

  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    tick_div_d  = tick_div_q;
    msb_shift_d = msb_shift_q;
    lsb_shift_d = lsb_shift_q;
    sample_d    = sample_q;
    match_d     = match_q;
    done        = 1'b0;
    if (phase_q == PhIdle) begin
      if (start_req) begin
        phase_d     = PhCmdLo;
        bit_count_d = '0;
        tick_div_d  = '0;
        msb_shift_d = '0;
        lsb_shift_d = '0;
      end
    end else if (half_end) begin
      tick_div_d = '0;
      unique case (phase_q)
        PhCmdLo: phase_d = PhCmdHi;
        PhCmdHi: begin
          if (bit_count_q >= LastCmdBit) begin
            phase_d     = PhRdLo;
            bit_count_d = '0;
          end else begin
            phase_d     = PhCmdLo;
            bit_count_d = bit_count_q + CountW'(1);
          end
        end
        PhRdLo: begin
          if (bit_count_q >= FirstMsbBit && bit_count_q <= LastMsbBit) begin
            msb_shift_d = {msb_shift_q[SampleBits-2:0], dio_in};
          end
          if (bit_count_q >= LastMsbBit) begin
            lsb_shift_d = {dio_in, lsb_shift_q[SampleBits-1:1]};
          end
          phase_d = PhRdHi;
        end
        PhRdHi: begin
          if (bit_count_q >= LastReadBit) begin
            phase_d     = PhEndLo;
            bit_count_d = '0;
          end else begin
            phase_d     = PhRdLo;
            bit_count_d = bit_count_q + CountW'(1);
          end
        end
        PhEndLo: begin
          match_d     = (msb_shift_q == lsb_shift_q);
          sample_d    = match_d ? msb_shift_q : '0;
          phase_d     = PhIdle;
          bit_count_d = '0;
          done        = 1'b1;
        end
        default: begin
          phase_d     = PhIdle;
          bit_count_d = '0;
        end
      endcase
    end else begin
      tick_div_d = tick_div_q + DivW'(1);
    end
  end

  always_comb begin
    unique case (bit_count_d)
      4'd0:    cmd_bit = 1'b1;
      4'd1:    cmd_bit = single_ended_q;
      default: cmd_bit = channel_q;
    endcase
    res_d.chip_select_n = (phase_d == PhIdle);
    res_d.serial_clock  = (phase_d == PhCmdHi) || (phase_d == PhRdHi);
    res_d.data_drive    = (phase_d == PhCmdLo) || (phase_d == PhCmdHi);
    res_d.data_out      = res_d.data_drive && cmd_bit;
    res_d.done_res      = done;
    res_d.sample        = sample_d;
    res_d.match_ok      = match_d;
    res_d.alarm         = sample_d > threshold_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      bit_count_q <= '0;
      tick_div_q  <= '0;
      msb_shift_q <= '0;
      lsb_shift_q <= '0;
      sample_q    <= '0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q     <= phase_d;
        bit_count_q <= bit_count_d;
        tick_div_q  <= tick_div_d;
        msb_shift_q <= msb_shift_d;
        lsb_shift_q <= lsb_shift_d;
        sample_q    <= sample_d;
        match_q     <= match_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  a_done_releases_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[0])
    else $error("done result without chip select released");

  a_drive_under_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[0])
    else $error("data line driven while chip select is high");

  a_idle_without_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q == PhIdle && !start_req |=> phase_q == PhIdle)
    else $error("conversion started without a request");

  a_cmd_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhCmdLo || phase_q == PhCmdHi) |-> bit_count_q <= LastCmdBit)
    else $error("command bit count out of range");

endmodule
`default_nettype wire
